@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define PSD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("psd assertion failed");

// antecedent in one cycle implies consequent in the next
`define PSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("psd assertion failed");

`endif

@@ hw/rtl/psd_pkg.sv @@
`default_nettype none
package psd_pkg;

	localparam int CoordW = 32;
	localparam int DiffW = 33;
	localparam int SqW = 66;
	localparam int DistW = 34;
	localparam int RootW = 35;
	localparam int SqrtValW = 70;
	localparam int SqrtRemW = 39;
	localparam int SelW = 35;
	localparam logic [31:0] ThrReset = 32'd1;
	localparam logic [31:0] TMax = 32'h7fff_ffff;
	localparam logic [31:0] TMin = 32'h8000_0000;
	localparam logic [0:0] RegThreshold = 1'b0;

	typedef enum logic [1:0] {
		KIND_START    = 2'd0,
		KIND_END      = 2'd1,
		KIND_INTERIOR = 2'd2
	} kind_t;

	// data that rides alongside the divider
	typedef struct packed {
		logic signed [DiffW-1:0]  rx;
		logic signed [DiffW-1:0]  ry;
		logic signed [DiffW-1:0]  pex;
		logic signed [DiffW-1:0]  pey;
		logic signed [DiffW-1:0]  dx;
		logic signed [DiffW-1:0]  dy;
		logic signed [CoordW-1:0] sx;
		logic signed [CoordW-1:0] sy;
		logic signed [CoordW-1:0] px;
		logic signed [CoordW-1:0] py;
		logic                     neg;
		logic                     over;
		logic                     degen;
	} div_side_t;

	// data that rides alongside the square root
	typedef struct packed {
		logic signed [CoordW-1:0] t;
		logic                     degen;
		kind_t                    kind;
	} res_side_t;

endpackage
`default_nettype wire

@@ hw/rtl/psd_in_if.sv @@
`default_nettype none
interface psd_in_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] seg_start_x;
	logic signed [31:0] seg_start_y;
	logic signed [31:0] seg_end_x;
	logic signed [31:0] seg_end_y;

	modport source (output valid, point_x, point_y, seg_start_x, seg_start_y,
		seg_end_x, seg_end_y, input ready);
	modport sink (input valid, point_x, point_y, seg_start_x, seg_start_y,
		seg_end_x, seg_end_y, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/psd_out_if.sv @@
`default_nettype none
interface psd_out_if;
	logic        valid;
	logic        ready;
	logic [33:0] distance;
	logic signed [31:0] projection_param;
	logic        degenerate;
	logic [1:0]  nearest_kind;

	modport source (output valid, distance, projection_param, degenerate, nearest_kind,
		input ready);
	modport sink (input valid, distance, projection_param, degenerate, nearest_kind,
		output ready);
endinterface
`default_nettype wire

@@ hw/rtl/point_segment_distance_unit.sv @@
// one result per input transaction
// throughput: one transaction per cycle; a stalled output holds the whole pipeline
// the divider takes 32 stages (one quotient bit each), the square root 35 stages
// reset clears all valid bits and sets the degenerate threshold to 1
`default_nettype none
module point_segment_distance_unit #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	psd_in_if.sink           in,
	psd_out_if.source        out
);
	localparam int F = COORD_FRAC_BITS;
	localparam int DW = psd_pkg::DiffW;
	localparam int SW = psd_pkg::SqW;
	localparam int CW = SW + 32 + F;
	localparam int PW = DW + F + 1;
	localparam int NDIV = 32;
	localparam int NSQ = psd_pkg::RootW;

	logic [31:0] thr;
	logic        en;

	psd_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.threshold(thr)
	);

	logic v_out_q;
	assign en = !v_out_q || out.ready;
	assign in.ready = en;

	// stage 1: differences
	logic v_s1;
	logic signed [DW-1:0] dx_s1, dy_s1, rx_s1, ry_s1, pex_s1, pey_s1;
	logic signed [31:0]   sx_s1, sy_s1, px_s1, py_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DW'(in.seg_end_x) - DW'(in.seg_start_x);
			dy_s1 <= DW'(in.seg_end_y) - DW'(in.seg_start_y);
			rx_s1 <= DW'(in.point_x) - DW'(in.seg_start_x);
			ry_s1 <= DW'(in.point_y) - DW'(in.seg_start_y);
			pex_s1 <= DW'(in.point_x) - DW'(in.seg_end_x);
			pey_s1 <= DW'(in.point_y) - DW'(in.seg_end_y);
			sx_s1 <= in.seg_start_x;
			sy_s1 <= in.seg_start_y;
			px_s1 <= in.point_x;
			py_s1 <= in.point_y;
		end
	end

	// stage 2: magnitude products
	logic [DW-1:0] mdx, mdy, mrx, mry;
	assign mdx = dx_s1[DW-1] ? -dx_s1 : dx_s1;
	assign mdy = dy_s1[DW-1] ? -dy_s1 : dy_s1;
	assign mrx = rx_s1[DW-1] ? -rx_s1 : rx_s1;
	assign mry = ry_s1[DW-1] ? -ry_s1 : ry_s1;

	logic v_s2, na_s2, nb_s2;
	logic [SW-1:0] dx2_s2, dy2_s2, ma_s2, mb_s2;
	psd_pkg::div_side_t side_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dx2_s2 <= SW'(mdx) * SW'(mdx);
			dy2_s2 <= SW'(mdy) * SW'(mdy);
			ma_s2 <= SW'(mrx) * SW'(mdx);
			mb_s2 <= SW'(mry) * SW'(mdy);
			na_s2 <= rx_s1[DW-1] != dx_s1[DW-1];
			nb_s2 <= ry_s1[DW-1] != dy_s1[DW-1];
			side_s2 <= '{rx: rx_s1, ry: ry_s1, pex: pex_s1, pey: pey_s1, dx: dx_s1,
				dy: dy_s1, sx: sx_s1, sy: sy_s1, px: px_s1, py: py_s1,
				neg: 1'b0, over: 1'b0, degen: 1'b0};
		end
	end

	// stage 3: squared length and signed dot magnitude
	logic v_s3;
	logic [SW-1:0] len2_s3, md_s3;
	psd_pkg::div_side_t side_s3;
	logic [SW-1:0] md_w;
	psd_pkg::div_side_t side3_w;
	always_comb begin
		side3_w = side_s2;
		if (na_s2 == nb_s2) begin
			md_w = ma_s2 + mb_s2;
			side3_w.neg = na_s2;
		end else if (ma_s2 >= mb_s2) begin
			md_w = ma_s2 - mb_s2;
			side3_w.neg = na_s2;
		end else begin
			md_w = mb_s2 - ma_s2;
			side3_w.neg = nb_s2;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			len2_s3 <= dx2_s2 + dy2_s2;
			md_s3 <= md_w;
			side_s3 <= side3_w;
		end
	end

	// stage 4: degenerate test and quotient overflow test
	logic v_s4;
	logic [CW-1:0] num_s4;
	logic [SW-1:0] den_s4;
	psd_pkg::div_side_t side_s4;
	logic [CW-1:0] num_w, lim_w;
	psd_pkg::div_side_t side4_w;
	assign num_w = CW'(md_s3) << F;
	assign lim_w = CW'(len2_s3) << 32;
	always_comb begin
		side4_w = side_s3;
		side4_w.over = num_w >= lim_w;
		side4_w.degen = len2_s3 <= SW'(thr);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			num_s4 <= num_w;
			den_s4 <= len2_s3;
			side_s4 <= side4_w;
		end
	end

	// divider chain
	logic               dv [NDIV+1];
	logic [CW-1:0]      drem [NDIV+1];
	logic [SW-1:0]      dden [NDIV+1];
	logic [31:0]        dq [NDIV+1];
	psd_pkg::div_side_t dside [NDIV+1];
	assign dv[0] = v_s4;
	assign drem[0] = num_s4;
	assign dden[0] = den_s4;
	assign dq[0] = '0;
	assign dside[0] = side_s4;

	for (genvar j = 0; j < NDIV; j++) begin : g_div
		psd_div_stage #(.W(CW), .SHIFT(NDIV - 1 - j)) u_stage (
			.clk(clk), .arst_n(arst_n), .en(en),
			.v_in(dv[j]), .rem_in(drem[j]), .den_in(dden[j]), .q_in(dq[j]),
			.side_in(dside[j]),
			.v_out(dv[j+1]), .rem_out(drem[j+1]), .den_out(dden[j+1]),
			.q_out(dq[j+1]), .side_out(dside[j+1])
		);
	end

	// stage 5: saturate t, pick nearest feature
	psd_pkg::div_side_t ds;
	logic [31:0] q;
	logic signed [31:0] t_w;
	psd_pkg::kind_t kind_w;
	assign ds = dside[NDIV];
	assign q = dq[NDIV];
	always_comb begin
		if (ds.degen) begin
			t_w = psd_pkg::TMax;
		end else if (!ds.neg) begin
			t_w = (ds.over || q[31]) ? psd_pkg::TMax : q;
		end else begin
			t_w = (ds.over || (q[31] && |q[30:0])) ? psd_pkg::TMin : -q;
		end
		if (ds.degen || t_w <= 0) kind_w = psd_pkg::KIND_START;
		else if (t_w >= (32'sd1 <<< F)) kind_w = psd_pkg::KIND_END;
		else kind_w = psd_pkg::KIND_INTERIOR;
	end

	logic v_s5;
	psd_pkg::div_side_t side_s5;
	psd_pkg::res_side_t res_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= dv[NDIV];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= ds;
			res_s5 <= '{t: t_w, degen: ds.degen, kind: kind_w};
		end
	end

	// stage 6: segment direction times t
	logic signed [F+1:0] tf;
	assign tf = $signed({1'b0, res_s5.t[F:0]});
	logic v_s6;
	psd_pkg::div_side_t side_s6;
	psd_pkg::res_side_t res_s6;
	logic signed [PW-1:0] prx_s6, pry_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			prx_s6 <= PW'(side_s5.dx) * PW'(tf);
			pry_s6 <= PW'(side_s5.dy) * PW'(tf);
			side_s6 <= side_s5;
			res_s6 <= res_s5;
		end
	end

	// stage 7: offset from the nearest point
	localparam int XW = psd_pkg::SelW + 1;
	logic signed [XW-1:0] qx, qy, ix, iy;
	logic signed [PW-1:0] shx, shy;
	assign shx = prx_s6 >>> F;
	assign shy = pry_s6 >>> F;
	assign qx = XW'(side_s6.sx) + XW'(shx);
	assign qy = XW'(side_s6.sy) + XW'(shy);
	assign ix = XW'(side_s6.px) - qx;
	assign iy = XW'(side_s6.py) - qy;

	logic v_s7;
	psd_pkg::res_side_t res_s7;
	logic signed [psd_pkg::SelW-1:0] ax_s7, ay_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			res_s7 <= res_s6;
			case (res_s6.kind)
				psd_pkg::KIND_END: begin
					ax_s7 <= psd_pkg::SelW'(side_s6.pex);
					ay_s7 <= psd_pkg::SelW'(side_s6.pey);
				end
				psd_pkg::KIND_INTERIOR: begin
					ax_s7 <= ix[psd_pkg::SelW-1:0];
					ay_s7 <= iy[psd_pkg::SelW-1:0];
				end
				default: begin
					ax_s7 <= psd_pkg::SelW'(side_s6.rx);
					ay_s7 <= psd_pkg::SelW'(side_s6.ry);
				end
			endcase
		end
	end

	// stage 8: squares
	localparam int MW = psd_pkg::SelW - 1;
	logic [psd_pkg::SelW-1:0] nax, nay;
	assign nax = ax_s7[psd_pkg::SelW-1] ? -ax_s7 : ax_s7;
	assign nay = ay_s7[psd_pkg::SelW-1] ? -ay_s7 : ay_s7;
	logic v_s8;
	psd_pkg::res_side_t res_s8;
	logic [2*MW-1:0] sqx_s8, sqy_s8;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (en) v_s8 <= v_s7;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s8 <= (2*MW)'(nax[MW-1:0]) * (2*MW)'(nax[MW-1:0]);
			sqy_s8 <= (2*MW)'(nay[MW-1:0]) * (2*MW)'(nay[MW-1:0]);
			res_s8 <= res_s7;
		end
	end

	// stage 9: sum of squares
	logic v_s9;
	psd_pkg::res_side_t res_s9;
	logic [psd_pkg::SqrtValW-1:0] val_s9;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (en) v_s9 <= v_s8;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			val_s9 <= psd_pkg::SqrtValW'(sqx_s8) + psd_pkg::SqrtValW'(sqy_s8);
			res_s9 <= res_s8;
		end
	end

	// square root chain
	logic                          sv [NSQ+1];
	logic [psd_pkg::SqrtValW-1:0]  sval [NSQ+1];
	logic [psd_pkg::SqrtRemW-1:0]  srem [NSQ+1];
	logic [psd_pkg::RootW-1:0]     sroot [NSQ+1];
	psd_pkg::res_side_t            sside [NSQ+1];
	assign sv[0] = v_s9;
	assign sval[0] = val_s9;
	assign srem[0] = '0;
	assign sroot[0] = '0;
	assign sside[0] = res_s9;

	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		psd_sqrt_stage u_stage (
			.clk(clk), .arst_n(arst_n), .en(en),
			.v_in(sv[k]), .val_in(sval[k]), .rem_in(srem[k]), .root_in(sroot[k]),
			.side_in(sside[k]),
			.v_out(sv[k+1]), .val_out(sval[k+1]), .rem_out(srem[k+1]),
			.root_out(sroot[k+1]), .side_out(sside[k+1])
		);
	end

	// output register, distance clamped to 34 bits
	logic [psd_pkg::DistW-1:0] dist_q;
	psd_pkg::res_side_t        res_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_out_q <= 1'b0;
		else if (en) v_out_q <= sv[NSQ];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dist_q <= sroot[NSQ][psd_pkg::RootW-1] ? '1
				: sroot[NSQ][psd_pkg::DistW-1:0];
			res_q <= sside[NSQ];
		end
	end

	assign out.valid = v_out_q;
	assign out.distance = dist_q;
	assign out.projection_param = res_q.t;
	assign out.degenerate = res_q.degen;
	assign out.nearest_kind = res_q.kind;
endmodule
`default_nettype wire

@@ hw/rtl/psd_cfg.sv @@
`default_nettype none
module psd_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic      [31:0] threshold
);
	logic [31:0] thr_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= psd_pkg::ThrReset;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == psd_pkg::RegThreshold) begin
			thr_q <= pwdata;
		end
	end

	always_comb begin
		unique case (paddr[2])
			psd_pkg::RegThreshold: prdata = thr_q;
			default:               prdata = '0;
		endcase
	end

	assign threshold = thr_q;
endmodule
`default_nettype wire

@@ hw/rtl/psd_div_stage.sv @@
`default_nettype none
// one quotient bit of the restoring divider
module psd_div_stage #(
	parameter int W = 114,
	parameter int SHIFT = 31
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       v_in,
	input  wire logic [W-1:0]               rem_in,
	input  wire logic [psd_pkg::SqW-1:0]    den_in,
	input  wire logic [31:0]                q_in,
	input  wire psd_pkg::div_side_t         side_in,
	output logic                            v_out,
	output logic [W-1:0]                    rem_out,
	output logic [psd_pkg::SqW-1:0]         den_out,
	output logic [31:0]                     q_out,
	output psd_pkg::div_side_t              side_out
);
	logic [W-1:0] trial;
	logic         take;

	assign trial = W'(den_in) << SHIFT;
	assign take = rem_in >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= take ? rem_in - trial : rem_in;
			den_out <= den_in;
			q_out <= q_in | (take ? (32'd1 << SHIFT) : 32'd0);
			side_out <= side_in;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/psd_sqrt_stage.sv @@
`default_nettype none
// one root bit of the digit-by-digit square root
module psd_sqrt_stage (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire logic                            v_in,
	input  wire logic [psd_pkg::SqrtValW-1:0]    val_in,
	input  wire logic [psd_pkg::SqrtRemW-1:0]    rem_in,
	input  wire logic [psd_pkg::RootW-1:0]       root_in,
	input  wire psd_pkg::res_side_t              side_in,
	output logic                                 v_out,
	output logic [psd_pkg::SqrtValW-1:0]         val_out,
	output logic [psd_pkg::SqrtRemW-1:0]         rem_out,
	output logic [psd_pkg::RootW-1:0]            root_out,
	output psd_pkg::res_side_t                   side_out
);
	logic [psd_pkg::SqrtRemW-1:0] cat;
	logic [psd_pkg::SqrtRemW-1:0] trial;
	logic                         take;

	assign cat = {rem_in[psd_pkg::SqrtRemW-3:0],
		val_in[psd_pkg::SqrtValW-1:psd_pkg::SqrtValW-2]};
	assign trial = {2'b00, root_in, 2'b01};
	assign take = cat >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_out <= {val_in[psd_pkg::SqrtValW-3:0], 2'b00};
			rem_out <= take ? cat - trial : cat;
			root_out <= {root_in[psd_pkg::RootW-2:0], take};
			side_out <= side_in;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/psd_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module psd_checker #(
	parameter int FRAC = 16
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [33:0] distance,
	input wire logic [31:0] projection_param,
	input wire logic        degenerate,
	input wire logic [1:0]  nearest_kind
);
	// a waiting result keeps its payload
	`PSD_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(distance) && $stable(projection_param))

	// degenerate segment reports start point and the fixed t
	`PSD_ASSERT(a_degen, clk, arst_n, !(out_valid && degenerate) || (projection_param == psd_pkg::TMax && nearest_kind == psd_pkg::KIND_START))

	// interior projection only for t strictly between zero and one
	`PSD_ASSERT(a_interior, clk, arst_n, !(out_valid && nearest_kind == psd_pkg::KIND_INTERIOR) || (!degenerate && !projection_param[31] && projection_param != 32'd0 && projection_param < (32'd1 << FRAC)))

	// end point means t at or beyond one
	`PSD_ASSERT(a_end, clk, arst_n, !(out_valid && nearest_kind == psd_pkg::KIND_END) || (!degenerate && !projection_param[31] && projection_param >= (32'd1 << FRAC)))
endmodule

bind point_segment_distance_unit psd_checker #(.FRAC(COORD_FRAC_BITS)) u_psd_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out.valid), .out_ready(out.ready),
	.distance(out.distance), .projection_param(out.projection_param),
	.degenerate(out.degenerate), .nearest_kind(out.nearest_kind)
);
`default_nettype wire
